// ===== design/proximity_steering_learner_macros.svh =====
// ----------------------------------------------------------------------------
// Proximity steering learner: assertion macros
// Short forms for clocked checks; the module that uses them must have
// i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_STEERING_LEARNER_MACROS_SVH
`define PROXIMITY_STEERING_LEARNER_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define PSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define PSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg
// Types, constants and helpers shared by the proximity steering learner.
// ----------------------------------------------------------------------------
package psl_pkg;

    localparam int NUM_SENSORS = 5;
    localparam int SENS_IDX_W  = $clog2(NUM_SENSORS);

    // field widths
    localparam int ACT_W   = 17;            // Q1.16 activation, 0..1.0
    localparam int CFG_W   = 16;            // config data width
    localparam int W_W     = 32;            // Q15.16 weight / steering
    localparam int CSUM_W  = ACT_W + 2;     // sum of five closeness values
    localparam int DIFF_W  = ACT_W + 1;
    localparam int DIR_W   = DIFF_W + 8;    // 90 * diff + 40 * diff

    localparam logic [ACT_W-1:0] ONE_Q16   = ACT_W'(65536);
    // sum(c) * 10 >= 1.0  <=>  sum(c) >= ceil(65536 / 10)
    localparam logic [CSUM_W-1:0] CLOSE_MIN = CSUM_W'((65536 + 9) / 10);

    localparam logic signed [DIR_W-1:0] OFFSET_WIDE = DIR_W'(90);
    localparam logic signed [DIR_W-1:0] OFFSET_NEAR = DIR_W'(40);

    // multi-limb product of five activations: up to 81 bits
    localparam int LIMB_W  = 32;
    localparam int NUM_LIMBS = 3;
    localparam int BIG_W   = LIMB_W * NUM_LIMBS;
    localparam int CARRY_W = 18;
    localparam int T_W     = LIMB_W + CARRY_W;

    // shared multipliers: signed 33 x 18
    localparam int MUL_A_W = W_W + 1;
    localparam int MUL_B_W = ACT_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PW_W    = W_W + ACT_W;   // weight * activation
    localparam int ACC_W   = PW_W + 3;      // sum of five products
    localparam int FRAC_W  = 16;
    localparam int STEER_W = ACC_W - FRAC_W;
    localparam int SUM_W   = W_W + 1;       // weight +/- increment

    // sequencing
    localparam int LIMB_CW    = 2;
    localparam int STEP_CW    = 2;
    localparam int LAST_LIMB  = NUM_LIMBS - 1;
    localparam int LAST_STEP  = NUM_SENSORS - 2;
    localparam int WCNT_W     = 3;
    localparam int INC_LAST   = NUM_SENSORS - 1;
    localparam int WUP_FIRST  = 1;
    localparam int WUP_LAST   = NUM_SENSORS;
    localparam int PW_FIRST   = 2;
    localparam int PW_LAST    = NUM_SENSORS + 1;
    localparam int ACC_FIRST  = 3;
    localparam int WGT_LAST   = NUM_SENSORS + 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(19661);
    localparam logic [CFG_W-1:0] RATE_RST      = CFG_W'(32768);

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DECIDE,
        S_WGT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;        // latch a new item
        logic chain;       // one limb step of both product chains
        logic limb_first;  // first limb of a step, carry in is zero
        logic a_rot;       // rotate activation ring
        logic decide;      // register near flag, clear accumulator
        logic inc_en;      // compute one weight increment
        logic w_en;        // rotate weight ring through the adder
        logic upd;         // apply the increment
        logic pw_en;       // multiply one weight by its activation
        logic acc_en;      // accumulate one product
        logic out_load;    // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic near;
        logic train;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [W_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [W_W-1:0] r;
        if (v[SUM_W-1] != v[SUM_W-2]) begin
            r = v[SUM_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end else begin
            r = v[W_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W_W-1:0] sat_steer(
        input logic signed [STEER_W-1:0] v
    );
        logic signed [W_W-1:0] r;
        if ((v[STEER_W-1:W_W-1] == '0) || (v[STEER_W-1:W_W-1] == '1)) begin
            r = v[W_W-1:0];
        end else begin
            r = v[STEER_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== design/psl_ctrl.sv =====
// ----------------------------------------------------------------------------
// psl_ctrl
// Sequencer: product chains, decision, weight update and steering sum.
// ----------------------------------------------------------------------------
`include "proximity_steering_learner_macros.svh"

module psl_ctrl
    import psl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state               r_state, n_state;
    logic [STEP_CW-1:0]   r_step,  n_step;
    logic [LIMB_CW-1:0]   r_limb,  n_limb;
    logic [WCNT_W-1:0]    r_wcnt,  n_wcnt;
    logic                 r_armed, n_armed;
    logic                 r_upd,   n_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_limb  <= '0;
            r_wcnt  <= '0;
            r_armed <= 1'b1;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_limb  <= n_limb;
            r_wcnt  <= n_wcnt;
            r_armed <= n_armed;
            r_upd   <= n_upd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_limb  = r_limb;
        n_wcnt  = r_wcnt;
        n_armed = r_armed;
        n_upd   = r_upd;
        o_stall = 1'b1;
        o_cmd   = '0;
        o_cmd.upd = r_upd;

        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step  = '0;
                    n_limb  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.chain      = 1'b1;
                o_cmd.limb_first = (r_limb == '0);
                if (r_limb == LIMB_CW'(LAST_LIMB)) begin
                    o_cmd.a_rot = 1'b1;
                    n_limb = '0;
                    n_step = r_step + STEP_CW'(1);
                    if (r_step == STEP_CW'(LAST_STEP)) begin
                        n_state = S_DECIDE;
                    end
                end else begin
                    n_limb = r_limb + LIMB_CW'(1);
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                o_cmd.a_rot  = 1'b1;    // fifth turn restores the ring
                n_upd  = 1'b0;
                if (i_status.train) begin
                    if (i_status.near) begin
                        if (r_armed) begin
                            n_upd   = 1'b1;
                            n_armed = 1'b0;
                        end
                    end else begin
                        n_armed = 1'b1;
                    end
                end
                n_wcnt  = '0;
                n_state = S_WGT;
            end
            S_WGT: begin
                o_cmd.inc_en = (r_wcnt <= WCNT_W'(INC_LAST));
                o_cmd.w_en   = (r_wcnt >= WCNT_W'(WUP_FIRST)) &&
                               (r_wcnt <= WCNT_W'(WUP_LAST));
                o_cmd.pw_en  = (r_wcnt >= WCNT_W'(PW_FIRST)) &&
                               (r_wcnt <= WCNT_W'(PW_LAST));
                o_cmd.a_rot  = o_cmd.pw_en;
                o_cmd.acc_en = (r_wcnt >= WCNT_W'(ACC_FIRST));
                n_wcnt = r_wcnt + WCNT_W'(1);
                if (r_wcnt == WCNT_W'(WGT_LAST)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PSL_ASSERT_NEXT(a_accept_starts, (i_valid && !o_stall), (r_state == S_MUL), "accept did not start product chain")
    `PSL_ASSERT_NOW(a_upd_disarms, ((r_state == S_WGT) && r_upd), (!r_armed), "update left learner armed")

endmodule

// ===== design/psl_dp.sv =====
// ----------------------------------------------------------------------------
// psl_dp
// Datapath: activation/closeness rings, two limb-serial product chains on
// two shared multipliers, weight ring, steering accumulator, output register.
// ----------------------------------------------------------------------------
`include "proximity_steering_learner_macros.svh"

module psl_dp
    import psl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [ACT_W-1:0]        i_act [NUM_SENSORS],
    input  logic                    i_train_enable,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [W_W-1:0]   o_steering,
    output logic                    o_weights_updated,
    output logic                    o_near_collision,
    output logic [1:0]              o_collision_side
);

    logic [CFG_W-1:0]         r_thr_cfg, r_lr_cfg;
    logic [ACT_W-1:0]         r_a [NUM_SENSORS];
    logic [ACT_W-1:0]         r_c [NUM_SENSORS];
    logic signed [W_W-1:0]    r_w [NUM_SENSORS];
    logic [BIG_W-1:0]         r_prod, r_thrp;
    logic [CARRY_W-1:0]       r_carry, r_tcarry;
    logic                     r_train;
    logic                     r_close_ok;
    t_side                    r_side;
    logic                     r_near;
    logic [ACT_W-1:0]         r_inc;
    logic signed [PW_W-1:0]   r_pw;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;

    logic [ACT_W-1:0]         act_cl [NUM_SENSORS];
    logic signed [MUL_A_W-1:0] m0_a, m1_a;
    logic signed [MUL_B_W-1:0] m0_b, m1_b;
    logic signed [MUL_P_W-1:0] m0_p, m1_p;
    logic [CARRY_W-1:0]       carry_in, tcarry_in;
    logic [T_W-1:0]           t_prod, t_thr;
    logic [CSUM_W-1:0]        csum;
    logic signed [DIFF_W-1:0] diff_wide, diff_near;
    logic signed [DIR_W-1:0]  dir;
    logic                     close_ok;
    t_side                    side;
    logic signed [SUM_W-1:0]  w_ext, inc_ext, w_sum;
    logic signed [W_W-1:0]    w_next;

    // ---- input clamp ----
    always_comb begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
            act_cl[k] = (i_act[k] > ONE_Q16) ? ONE_Q16 : i_act[k];
        end
    end

    // ---- shared multipliers: chains in S_MUL, increment / steering later ----
    assign m0_a = i_cmd.chain ? {1'b0, r_prod[LIMB_W-1:0]}
                              : {(MUL_A_W-ACT_W)'(0), r_c[0]};
    assign m0_b = i_cmd.chain ? {1'b0, r_a[1]}
                              : {(MUL_B_W-CFG_W)'(0), r_lr_cfg};
    assign m1_a = i_cmd.chain ? {1'b0, r_thrp[LIMB_W-1:0]}
                              : {r_w[NUM_SENSORS-1][W_W-1], r_w[NUM_SENSORS-1]};
    assign m1_b = i_cmd.chain ? {(MUL_B_W-CFG_W)'(0), r_thr_cfg}
                              : {1'b0, r_a[0]};
    assign m0_p = m0_a * m0_b;
    assign m1_p = m1_a * m1_b;

    assign carry_in  = i_cmd.limb_first ? '0 : r_carry;
    assign tcarry_in = i_cmd.limb_first ? '0 : r_tcarry;
    assign t_prod = m0_p[T_W-1:0] + {(T_W-CARRY_W)'(0), carry_in};
    assign t_thr  = m1_p[T_W-1:0] + {(T_W-CARRY_W)'(0), tcarry_in};

    // ---- side and closeness ----
    assign csum = CSUM_W'(r_c[0]) + CSUM_W'(r_c[1]) + CSUM_W'(r_c[2])
                + CSUM_W'(r_c[3]) + CSUM_W'(r_c[4]);
    assign diff_wide = $signed({1'b0, r_c[4]}) - $signed({1'b0, r_c[0]});
    assign diff_near = $signed({1'b0, r_c[3]}) - $signed({1'b0, r_c[1]});
    assign dir = DIR_W'(diff_wide) * OFFSET_WIDE + DIR_W'(diff_near) * OFFSET_NEAR;
    assign close_ok = (csum >= CLOSE_MIN);

    always_comb begin
        side = SIDE_NONE;
        if (close_ok) begin
            if (dir < 0) begin
                side = SIDE_LEFT;
            end else if (dir > 0) begin
                side = SIDE_RIGHT;
            end
        end
    end

    // ---- weight adder, saturating ----
    assign w_ext   = SUM_W'(r_w[0]);
    assign inc_ext = $signed({(SUM_W-ACT_W)'(0), r_inc});
    always_comb begin
        case (r_side)
            SIDE_LEFT:  w_sum = w_ext + inc_ext;
            SIDE_RIGHT: w_sum = w_ext - inc_ext;
            default:    w_sum = w_ext;
        endcase
        w_next = i_cmd.upd ? sat_sum(w_sum) : r_w[0];
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_cfg <= THRESHOLD_RST;
            r_lr_cfg  <= RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr_cfg <= i_cfg_data;
                CFG_RATE:      r_lr_cfg  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // ---- weights (learned state) ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_w[k] <= '0;
            end
        end else if (i_cmd.w_en) begin
            for (int k = 0; k < NUM_SENSORS - 1; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[NUM_SENSORS-1] <= w_next;
        end
    end

    // ---- item payload and working registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_a[k] <= act_cl[k];
                r_c[k] <= ONE_Q16 - act_cl[k];
            end
            r_train <= i_train_enable;
            r_prod  <= BIG_W'(act_cl[0]);
            r_thrp  <= BIG_W'(r_thr_cfg);
        end else begin
            if (i_cmd.a_rot) begin
                for (int k = 0; k < NUM_SENSORS - 1; k++) begin
                    r_a[k] <= r_a[k+1];
                end
                r_a[NUM_SENSORS-1] <= r_a[0];
            end
            if (i_cmd.inc_en) begin
                for (int k = 0; k < NUM_SENSORS - 1; k++) begin
                    r_c[k] <= r_c[k+1];
                end
                r_c[NUM_SENSORS-1] <= r_c[0];
            end
        end

        if (i_cmd.chain) begin
            r_prod   <= {t_prod[LIMB_W-1:0], r_prod[BIG_W-1:LIMB_W]};
            r_thrp   <= {t_thr[LIMB_W-1:0],  r_thrp[BIG_W-1:LIMB_W]};
            r_carry  <= t_prod[T_W-1:LIMB_W];
            r_tcarry <= t_thr[T_W-1:LIMB_W];
            r_close_ok <= close_ok;
            r_side     <= side;
        end
        if (i_cmd.decide) begin
            r_near <= o_status.near;
            r_acc  <= '0;
        end
        if (i_cmd.inc_en) begin
            r_inc <= m0_p[FRAC_W+ACT_W-1:FRAC_W];
        end
        if (i_cmd.pw_en) begin
            r_pw <= m1_p[PW_W-1:0];
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_pw);
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_steering        <= sat_steer(r_acc[ACC_W-1:FRAC_W]);
            o_weights_updated <= i_cmd.upd;
            o_near_collision  <= r_near;
            o_collision_side  <= r_side;
        end
    end

    assign o_valid = r_out_valid;

    assign o_status.near     = r_close_ok && (r_prod < r_thrp);
    assign o_status.train    = r_train;
    assign o_status.out_free = !r_out_valid || !i_stall;

    `PSL_ASSERT_NOW(a_chain_no_overflow, i_cmd.decide, ((r_carry == '0) && (r_tcarry == '0)), "product chain carried out of top limb")
    `PSL_ASSERT_NOW(a_update_needs_near, (o_valid && o_weights_updated), o_near_collision, "weights updated without near collision")

endmodule

// ===== design/proximity_steering_learner.sv =====
// ----------------------------------------------------------------------------
// proximity_steering_learner
// Online-trained steering from five proximity sensors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): each transfer carries five
//   Q1.16 activations (left .. right, 1.0 = clear) and the training flag.
//   Output channel (o_valid / i_stall): one transfer per input item with the
//   saturated Q15.16 steering value, the weights-updated flag, the near
//   collision flag and the side code.
//   Config port: i_cfg_we writes i_cfg_data to the threshold (index 0) or
//   the learning rate (index 1); write only while the block is idle.
// Sequence:
//   The product test runs four limb multiply steps of three 32-bit limbs
//   each on two shared multipliers (S_MUL), followed by a decision state
//   (S_DECIDE), the pipelined update / weighted sum (S_WGT) and the load
//   of the output register (S_FIN). A new item is taken only in S_IDLE,
//   after the previous one has been handed to the output register.
// Reset (synchronous, active low): weights zero, learner armed, registers at
//   their defaults, output empty.
// Back-pressure: a result sits in the output register while i_stall is high;
//   the next item is taken and processed meanwhile and waits in its last
//   step until the register frees up.
// ----------------------------------------------------------------------------
module proximity_steering_learner
    import psl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [ACT_W-1:0]       i_act_left,
    input  logic [ACT_W-1:0]       i_act_left_wide,
    input  logic [ACT_W-1:0]       i_act_center,
    input  logic [ACT_W-1:0]       i_act_right_wide,
    input  logic [ACT_W-1:0]       i_act_right,
    input  logic                   i_train_enable,
    // output channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [W_W-1:0]  o_steering,
    output logic                   o_weights_updated,
    output logic                   o_near_collision,
    output logic [1:0]             o_collision_side
);

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [ACT_W-1:0] act [NUM_SENSORS];

    // sensor order: angle offsets -90, -40, 0, +40, +90 degrees
    assign act[0] = i_act_left;
    assign act[1] = i_act_left_wide;
    assign act[2] = i_act_center;
    assign act[3] = i_act_right_wide;
    assign act[4] = i_act_right;

    // sequencer: owns the armed flag and the update decision
    psl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic, weights, config and the output register
    psl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_act             (act),
        .i_train_enable    (i_train_enable),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_steering        (o_steering),
        .o_weights_updated (o_weights_updated),
        .o_near_collision  (o_near_collision),
        .o_collision_side  (o_collision_side)
    );

endmodule
